// File: src/kvrs_pkg.sv
// ----------------------------------------------------------------------------
// kvrs_pkg
// Shared types, sizes and compare functions for the key/value result sorter.
// ----------------------------------------------------------------------------
package kvrs_pkg;

    localparam int CAPACITY = 64;
    localparam int LABEL_W  = 64;
    localparam int DIST_W   = 32;
    localparam int MODE_W   = 2;
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int WAIT_W   = $clog2(CAPACITY);

    localparam logic [MODE_W-1:0] SORT_NONE = 2'd0;
    localparam logic [MODE_W-1:0] SORT_ASC  = 2'd1;
    localparam logic [MODE_W-1:0] SORT_DESC = 2'd2;

    typedef struct packed {
        logic                      valid;
        logic signed [LABEL_W-1:0] label;
        logic [DIST_W-1:0]         dist_bits;
    } entry_t;

    // push: the sequence is already shifting, the cell must take the entry
    typedef struct packed {
        entry_t ent;
        logic   push;
    } cand_t;

    function automatic logic [DIST_W-1:0] order_key(input logic [DIST_W-1:0] bits);
        logic [DIST_W-1:0] b;
        b = bits;
        if (b == {1'b1, {(DIST_W-1){1'b0}}})
            b = '0;
        if (b[DIST_W-1])
            return ~b;
        return b | {1'b1, {(DIST_W-1){1'b0}}};
    endfunction

    function automatic logic goes_before(input logic [DIST_W-1:0] a,
                                         input logic [DIST_W-1:0] b,
                                         input logic [MODE_W-1:0] mode);
        logic [DIST_W-1:0] ka;
        logic [DIST_W-1:0] kb;
        logic              res;
        ka = order_key(a);
        kb = order_key(b);
        case (mode)
            SORT_ASC:  res = (ka < kb);
            SORT_DESC: res = (ka > kb);
            default:   res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: src/key_value_result_sorter_top.sv
// ----------------------------------------------------------------------------
// key_value_result_sorter_top
// Systolic insertion sorter for (label, distance) result sets.
// ----------------------------------------------------------------------------
// Input requests (in_valid/in_stall) carry label, distance and last. One
// request is taken per cycle while loading; each enters a row of CAPACITY
// cells that keeps the set ordered as it arrives. Requests beyond CAPACITY
// are dropped and flag overflow on the whole run.
// After the request with last, in_stall is held while the final insertion
// wave runs down the row, then the run of N results streams out
// (out_valid/out_stall) at one per cycle from the head cell while out_stall
// is low, last_res on the final one. The settle wait is set by the row
// length; each result passes through an output register. After the final
// result the row returns to loading. A stalled result holds in the output
// register and the row waits behind it.
// cfg_wr_data sets the order (0 none, 1 ascending, 2 descending); write it
// only between sets. Reset empties the row, selects ascending order.
// ----------------------------------------------------------------------------
module key_value_result_sorter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [kvrs_pkg::MODE_W-1:0]         cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [kvrs_pkg::LABEL_W-1:0] label,
    input  logic [kvrs_pkg::DIST_W-1:0]         distance,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [kvrs_pkg::LABEL_W-1:0] label_res,
    output logic [kvrs_pkg::DIST_W-1:0]         distance_res,
    output logic                                last_res,
    output logic                                overflow
);

    typedef enum logic [1:0] {ST_LOAD, ST_SETTLE, ST_DRAIN} state_t;

    state_t                          state_reg;
    logic [kvrs_pkg::MODE_W-1:0]     mode_reg;
    logic [kvrs_pkg::FILL_W-1:0]     fill_reg;
    logic                            ovf_reg;
    logic [kvrs_pkg::WAIT_W-1:0]     wait_reg;
    logic [kvrs_pkg::FILL_W-1:0]     remain_reg;
    logic                            run_ovf_reg;
    logic                            out_valid_reg;
    logic                            last_res_reg;
    logic                            overflow_reg;
    logic signed [kvrs_pkg::LABEL_W-1:0] label_res_reg;
    logic [kvrs_pkg::DIST_W-1:0]     distance_res_reg;

    logic                            accept;
    logic                            has_room;
    logic                            take;
    logic                            shift_en;

    kvrs_pkg::cand_t  cand   [0:kvrs_pkg::CAPACITY];
    kvrs_pkg::entry_t stored [0:kvrs_pkg::CAPACITY];

    assign in_stall = (state_reg != ST_LOAD);
    assign accept   = in_valid && !in_stall;
    assign has_room = (fill_reg < kvrs_pkg::FILL_W'(kvrs_pkg::CAPACITY));
    assign take     = !out_valid_reg || !out_stall;
    assign shift_en = (state_reg == ST_DRAIN) && (remain_reg != '0) && take;

    assign cand[0].ent.valid     = accept && has_room;
    assign cand[0].ent.label     = label;
    assign cand[0].ent.dist_bits = distance;
    assign cand[0].push          = 1'b0;
    assign stored[kvrs_pkg::CAPACITY] = '0;

    for (genvar i = 0; i < kvrs_pkg::CAPACITY; i++)
    begin : g_cell
        kvrs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .mode     (mode_reg),
            .cand_in  (cand[i]),
            .shift_en (shift_en),
            .shift_in (stored[i+1]),
            .cand_out (cand[i+1]),
            .stored   (stored[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            mode_reg      <= kvrs_pkg::SORT_ASC;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            wait_reg      <= '0;
            remain_reg    <= '0;
            run_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            out_valid_reg <= shift_en || (out_valid_reg && out_stall);
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (has_room)
                            fill_reg <= fill_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                        if (last)
                        begin
                            state_reg   <= ST_SETTLE;
                            wait_reg    <= kvrs_pkg::WAIT_W'(kvrs_pkg::CAPACITY - 1);
                            remain_reg  <= has_room ? fill_reg + 1'b1 : fill_reg;
                            run_ovf_reg <= ovf_reg || !has_room;
                        end
                    end
                end
                ST_SETTLE:
                begin
                    if (wait_reg == '0)
                        state_reg <= ST_DRAIN;
                    else
                        wait_reg <= wait_reg - 1'b1;
                end
                ST_DRAIN:
                begin
                    if (shift_en)
                    begin
                        remain_reg <= remain_reg - 1'b1;
                        if (remain_reg == kvrs_pkg::FILL_W'(1))
                        begin
                            state_reg <= ST_LOAD;
                            fill_reg  <= '0;
                            ovf_reg   <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            label_res_reg    <= stored[0].label;
            distance_res_reg <= stored[0].dist_bits;
            last_res_reg     <= (remain_reg == kvrs_pkg::FILL_W'(1));
            overflow_reg     <= run_ovf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign label_res    = label_res_reg;
    assign distance_res = distance_res_reg;
    assign last_res     = last_res_reg;
    assign overflow     = overflow_reg;

    a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
        !cand[kvrs_pkg::CAPACITY].ent.valid)
        else $error("entry pushed past the last cell");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        shift_en |-> stored[0].valid)
        else $error("drain read an empty head cell");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= kvrs_pkg::FILL_W'(kvrs_pkg::CAPACITY))
        else $error("fill count beyond capacity");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (shift_en && (remain_reg == kvrs_pkg::FILL_W'(1)))
        |=> ((state_reg == ST_LOAD) && (remain_reg == '0)))
        else $error("final result sent with entries left");

    a_settle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (in_stall && !shift_en))
        else $error("run started before the set settled");

endmodule

// File: src/kvrs_cell.sv
// ----------------------------------------------------------------------------
// kvrs_cell
// One insertion cell: holds one entry, keeps the earlier of stored and
// incoming, hands the other to the next cell; shifts toward the head on drain.
// ----------------------------------------------------------------------------
module kvrs_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [kvrs_pkg::MODE_W-1:0]  mode,
    input  kvrs_pkg::cand_t              cand_in,
    input  logic                         shift_en,
    input  kvrs_pkg::entry_t             shift_in,
    output kvrs_pkg::cand_t              cand_out,
    output kvrs_pkg::entry_t             stored
);

    kvrs_pkg::entry_t stored_reg;
    kvrs_pkg::entry_t stored_next;
    kvrs_pkg::cand_t  cand_reg;
    kvrs_pkg::cand_t  cand_next;

    always_comb
    begin
        stored_next = stored_reg;
        cand_next   = cand_reg;
        cand_next.ent.valid = 1'b0;
        cand_next.push      = 1'b0;
        if (shift_en)
        begin
            stored_next = shift_in;
        end
        else if (cand_in.ent.valid)
        begin
            if (!stored_reg.valid)
            begin
                stored_next = cand_in.ent;
            end
            else if (cand_in.push ||
                     kvrs_pkg::goes_before(cand_in.ent.dist_bits, stored_reg.dist_bits, mode))
            begin
                stored_next    = cand_in.ent;
                cand_next.ent  = stored_reg;
                cand_next.push = 1'b1;
            end
            else
            begin
                cand_next = cand_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            cand_reg   <= '0;
        end
        else
        begin
            stored_reg <= stored_next;
            cand_reg   <= cand_next;
        end
    end

    assign cand_out = cand_reg;
    assign stored   = stored_reg;

endmodule
